### hw/rtl/ordered_array_list_engine_core_macros.svh
// Assertion macros shared by the ordered array list engine RTL.
// No dependencies; the macros expect clk and arst_n in the using module.
`ifndef ORDERED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`define ORDERED_ARRAY_LIST_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define OALE_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("oale assertion failed");
// expression must never be true outside reset
`define OALE_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("oale forbidden condition seen");
`else
`define OALE_ASSERT(lbl, prop)
`define OALE_NEVER(lbl, expr)
`endif
`endif

### hw/rtl/oale_pkg.sv
// Shared types and codes of the ordered array list engine.
// No dependencies.
package oale_pkg;

	localparam int OP_W  = 3;
	localparam int POS_W = 8;
	localparam int VAL_W = 32;
	localparam int STS_W = 2;

	// request codes (code 7 is unused and behaves as a no-op)
	localparam logic [OP_W-1:0] OP_GET    = 3'd0;
	localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
	localparam logic [OP_W-1:0] OP_PRIOR  = 3'd2;
	localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
	localparam logic [OP_W-1:0] OP_INSERT = 3'd4;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd5;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd6;

	// result status codes
	localparam logic [STS_W-1:0] STS_OK     = 2'd0;
	localparam logic [STS_W-1:0] STS_BADPOS = 2'd1;
	localparam logic [STS_W-1:0] STS_NONE   = 2'd2;
	localparam logic [STS_W-1:0] STS_FULL   = 2'd3;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_NREAD,
		ST_PEEK,
		ST_MOVE,
		ST_PUT,
		ST_EMIT
	} state_t;

	// one result transaction
	typedef struct packed {
		logic [STS_W-1:0]        status;
		logic signed [VAL_W-1:0] value_out;
		logic [POS_W-1:0]        found_position;
		logic [POS_W-1:0]        list_length;
		logic                    is_empty;
	} res_t;

endpackage

### hw/rtl/oale_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module oale_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/oale_seq.sv
// Sequencer and datapath of the list engine: request decode, scan, shift and count.
// Depends on oale_pkg and ordered_array_list_engine_core_macros.svh.
`include "ordered_array_list_engine_core_macros.svh"
module oale_seq #(
	parameter int CAPACITY = 128
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// request side
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [oale_pkg::OP_W-1:0]             op,
	input  logic [oale_pkg::POS_W-1:0]            pos,
	input  logic signed [oale_pkg::VAL_W-1:0]     value,
	// element store
	output logic                                  wr_en,
	output logic [$clog2(CAPACITY)-1:0]           wr_addr,
	output logic [oale_pkg::VAL_W-1:0]            wr_data,
	output logic                                  rd_en,
	output logic [$clog2(CAPACITY)-1:0]           rd_addr,
	input  logic [oale_pkg::VAL_W-1:0]            rd_data,
	// result side
	output logic                                  emit_valid,
	input  logic                                  emit_room,
	output oale_pkg::res_t                        res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = ((CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W) + 1;

	oale_pkg::state_t state_q, state_d;

	logic [CW-1:0]                  cnt_q, cnt_d;
	logic [CW-1:0]                  cur_q, cur_d;
	logic [AW-1:0]                  lim_q, lim_d;
	logic [AW-1:0]                  base_q, base_d;
	logic [AW-1:0]                  pidx_q, pidx_d;
	logic                           pv_q, pv_d;
	logic                           iss_q, iss_d;
	logic [oale_pkg::OP_W-1:0]      op_q, op_d;
	logic signed [oale_pkg::VAL_W-1:0] val_q, val_d;
	logic [oale_pkg::STS_W-1:0]     sts_q, sts_d;
	logic signed [oale_pkg::VAL_W-1:0] vout_q, vout_d;
	logic [oale_pkg::POS_W-1:0]     fpos_q, fpos_d;

	logic [XW-1:0] pos_x, cnt_x, pidx_x;
	logic          ok_get, ok_ins, hit, is_ins;
	logic [AW-1:0] pos_m1;
	logic          cnt_still;

	// position checks against the current length (shared compare unit)
	assign pos_x  = XW'(pos);
	assign cnt_x  = XW'(cnt_q);
	assign pidx_x = XW'(pidx_q);
	assign ok_get = (pos_x != '0) && (pos_x <= cnt_x);
	assign ok_ins = (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
	assign pos_m1 = AW'(pos_x - 1'b1);
	assign hit    = pv_q && (rd_data == val_q);
	assign is_ins = (op_q == oale_pkg::OP_INSERT);

	// result fields come straight from the holding registers
	assign res.status         = sts_q;
	assign res.value_out      = vout_q;
	assign res.found_position = fpos_q;
	assign res.list_length    = oale_pkg::POS_W'(cnt_q);
	assign res.is_empty       = (cnt_q == '0);

	// next state and datapath control
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cur_d      = cur_q;
		lim_d      = lim_q;
		base_d     = base_q;
		pidx_d     = pidx_q;
		pv_d       = pv_q;
		iss_d      = iss_q;
		op_d       = op_q;
		val_d      = val_q;
		sts_d      = sts_q;
		vout_d     = vout_q;
		fpos_d     = fpos_q;
		in_ready   = 1'b0;
		emit_valid = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = cur_q[AW-1:0];
		wr_en      = 1'b0;
		wr_addr    = base_q;
		wr_data    = val_q;
		unique case (state_q)
			oale_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					op_d   = op;
					val_d  = value;
					sts_d  = oale_pkg::STS_OK;
					vout_d = '0;
					fpos_d = '0;
					cur_d  = '0;
					pv_d   = 1'b0;
					iss_d  = 1'b0;
					state_d = oale_pkg::ST_EMIT;
					case (op) inside
						oale_pkg::OP_GET: begin
							if (ok_get) begin
								cur_d   = CW'(pos_x - 1'b1);
								state_d = oale_pkg::ST_NREAD;
							end else begin
								sts_d = oale_pkg::STS_BADPOS;
							end
						end
						oale_pkg::OP_LOCATE, oale_pkg::OP_PRIOR, oale_pkg::OP_NEXT: begin
							state_d = oale_pkg::ST_SCAN;
						end
						oale_pkg::OP_INSERT: begin
							if (!ok_ins) begin
								sts_d = oale_pkg::STS_BADPOS;
							end else if (cnt_q >= CW'(CAPACITY)) begin
								sts_d = oale_pkg::STS_FULL;
							end else begin
								base_d = pos_m1;
								lim_d  = pos_m1;
								if (pos_x <= cnt_x) begin
									cur_d   = cnt_q - 1'b1;
									iss_d   = 1'b1;
									state_d = oale_pkg::ST_MOVE;
								end else begin
									state_d = oale_pkg::ST_PUT;
								end
							end
						end
						oale_pkg::OP_DELETE: begin
							if (ok_get) begin
								base_d  = pos_m1;
								lim_d   = AW'(cnt_q - 1'b1);
								cur_d   = CW'(pos_x - 1'b1);
								iss_d   = 1'b1;
								state_d = oale_pkg::ST_MOVE;
							end else begin
								sts_d = oale_pkg::STS_BADPOS;
							end
						end
						oale_pkg::OP_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			// walk the store one entry a cycle, compare each entry in the cycle after its read
			oale_pkg::ST_SCAN: begin
				if (cur_q < cnt_q) begin
					rd_en  = 1'b1;
					pv_d   = 1'b1;
					pidx_d = cur_q[AW-1:0];
					cur_d  = cur_q + 1'b1;
				end else begin
					pv_d = 1'b0;
				end
				if (hit) begin
					fpos_d = oale_pkg::POS_W'(pidx_x + 1'b1);
					case (op_q)
						oale_pkg::OP_PRIOR: begin
							if (pidx_q != '0) begin
								cur_d   = CW'(pidx_x - 1'b1);
								state_d = oale_pkg::ST_NREAD;
							end else begin
								sts_d   = oale_pkg::STS_NONE;
								state_d = oale_pkg::ST_EMIT;
							end
						end
						oale_pkg::OP_NEXT: begin
							if (pidx_x + 1'b1 < cnt_x) begin
								cur_d   = CW'(pidx_x + 1'b1);
								state_d = oale_pkg::ST_NREAD;
							end else begin
								sts_d   = oale_pkg::STS_NONE;
								state_d = oale_pkg::ST_EMIT;
							end
						end
						default: begin
							vout_d  = val_q;
							state_d = oale_pkg::ST_EMIT;
						end
					endcase
				end else if (cur_q >= cnt_q) begin
					sts_d   = oale_pkg::STS_NONE;
					state_d = oale_pkg::ST_EMIT;
				end
			end
			// single fetch for get and neighbour lookups
			oale_pkg::ST_NREAD: begin
				rd_en   = 1'b1;
				state_d = oale_pkg::ST_PEEK;
			end
			oale_pkg::ST_PEEK: begin
				vout_d  = rd_data;
				state_d = oale_pkg::ST_EMIT;
			end
			// shift: read one entry, write it one place over on the next cycle
			oale_pkg::ST_MOVE: begin
				if (iss_q) begin
					rd_en  = 1'b1;
					pv_d   = 1'b1;
					pidx_d = cur_q[AW-1:0];
					if (cur_q[AW-1:0] == lim_q) begin
						iss_d = 1'b0;
					end else if (is_ins) begin
						cur_d = cur_q - 1'b1;
					end else begin
						cur_d = cur_q + 1'b1;
					end
				end else begin
					pv_d = 1'b0;
				end
				if (pv_q) begin
					if (!is_ins && (pidx_q == base_q)) begin
						vout_d = rd_data;
					end else begin
						wr_en   = 1'b1;
						wr_addr = is_ins ? (pidx_q + 1'b1) : (pidx_q - 1'b1);
						wr_data = rd_data;
					end
				end
				if (!iss_q) begin
					if (is_ins) begin
						state_d = oale_pkg::ST_PUT;
					end else begin
						cnt_d   = cnt_q - 1'b1;
						state_d = oale_pkg::ST_EMIT;
					end
				end
			end
			oale_pkg::ST_PUT: begin
				wr_en   = 1'b1;
				cnt_d   = cnt_q + 1'b1;
				state_d = oale_pkg::ST_EMIT;
			end
			oale_pkg::ST_EMIT: begin
				emit_valid = 1'b1;
				if (emit_room) begin
					state_d = oale_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = oale_pkg::ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= oale_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pv_q  <= 1'b0;
			iss_q <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			pv_q  <= pv_d;
			iss_q <= iss_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		lim_q  <= lim_d;
		base_q <= base_d;
		pidx_q <= pidx_d;
		op_q   <= op_d;
		val_q  <= val_d;
		sts_q  <= sts_d;
		vout_q <= vout_d;
		fpos_q <= fpos_d;
	end

	// states that never touch the length
	assign cnt_still = (state_q == oale_pkg::ST_SCAN) || (state_q == oale_pkg::ST_NREAD) ||
		(state_q == oale_pkg::ST_PEEK) || (state_q == oale_pkg::ST_EMIT);

	`OALE_ASSERT(a_cnt_cap, cnt_q <= CW'(CAPACITY))
	`OALE_NEVER(a_no_wr_idle, (state_q == oale_pkg::ST_IDLE) && wr_en)
	`OALE_ASSERT(a_cnt_hold, cnt_still |=> $stable(cnt_q))

endmodule

### hw/rtl/oale_out.sv
// Output register of the list engine: holds one result transaction for the master side.
// Depends on oale_pkg.
module oale_out (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           room,
	input  oale_pkg::res_t res,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [55:0]    m_tdata,
	output logic [1:0]     m_tuser
);

	logic           vld_q;
	oale_pkg::res_t res_q;

	assign room = !vld_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (room) begin
			vld_q <= push;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (push && room) begin
			res_q <= res;
		end
	end

	// pack the stream fields
	assign m_tvalid = vld_q;
	assign m_tdata  = {7'b0, res_q.is_empty, res_q.list_length, res_q.found_position,
		res_q.value_out};
	assign m_tuser  = res_q.status;

endmodule

### hw/rtl/ordered_array_list_engine_core.sv
// Ordered array list engine: a fixed-capacity list of signed 32-bit values with
// 1-based positions. Each request transaction yields exactly one result transaction.
// Operation: all work goes through the single element RAM (one read and one write per
// cycle) under one sequencer, and one request is handled at a time. Clear, rejected
// requests and unused codes go straight to the result; get reads one entry; locate
// scans from the head; prior and next scan, then read the neighbour; insert shifts
// the entries from the end down to p up one place, then writes, and delete shifts
// the entries after p down one place. A finished result waits in the output
// register, so the next request is taken while it is pending.
// Depends on oale_pkg, oale_seq, oale_out and oale_ram.
module ordered_array_list_engine_core #(
	parameter int CAPACITY = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [7:0] position, [39:8] value
	input  logic [2:0]  s_tuser,   // [2:0] operation
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [31:0] value_out, [39:32] found_position,
	                               // [47:40] list_length, [48] is_empty, rest zero
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int AW = $clog2(CAPACITY);

	logic                              wr_en, rd_en;
	logic [AW-1:0]                     wr_addr, rd_addr;
	logic [oale_pkg::VAL_W-1:0]        wr_data, rd_data;
	logic                              emit_valid, emit_room;
	oale_pkg::res_t                    res;
	logic signed [oale_pkg::VAL_W-1:0] req_value;

	assign req_value = s_tdata[39:8];

	// request sequencer
	oale_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tuser),
		.pos       (s_tdata[7:0]),
		.value     (req_value),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.emit_valid(emit_valid),
		.emit_room (emit_room),
		.res       (res)
	);

	// element store
	oale_ram #(
		.WIDTH(oale_pkg::VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// result register
	oale_out u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (emit_valid),
		.room    (emit_room),
		.res     (res),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
